>>> src/radix_integer_to_ascii_macros.svh
// Assertion macros shared by the radix integer-to-ASCII converter RTL.
`ifndef RADIX_INTEGER_TO_ASCII_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_MACROS_SVH
`ifndef SYNTH
`define RITOA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");
`define RITOA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");
`else
`define RITOA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RITOA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> src/ritoa_pkg.sv
// Shared constants, types and the digit-to-character function of the converter.
package ritoa_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	// Radix mode codes carried on the func field.
	localparam logic [2:0] FUNC_BIN  = 3'd0;
	localparam logic [2:0] FUNC_OCT  = 3'd1;
	localparam logic [2:0] FUNC_DEC  = 3'd2;
	localparam logic [2:0] FUNC_HEXL = 3'd3;
	localparam logic [2:0] FUNC_HEXU = 3'd4;

	// Bits per digit for each radix.
	localparam logic [2:0] DIG_BITS_BIN = 3'd1;
	localparam logic [2:0] DIG_BITS_OCT = 3'd3;
	localparam logic [2:0] DIG_BITS_HEX = 3'd4;

	localparam logic [3:0] DEC_RADIX  = 4'd10;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_LOWER = 7'h61;
	localparam logic [6:0] CHAR_UPPER = 7'h41;

	typedef struct packed {
		logic       load;
		logic       decimal;
		logic [2:0] dig_bits;
		logic       upper;
	} emit_cmd_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] base;
		base = upper ? CHAR_UPPER : CHAR_LOWER;
		if (d < DEC_RADIX) begin
			return CHAR_ZERO + {3'b000, d};
		end
		return base + {3'b000, d} - {3'b000, DEC_RADIX};
	endfunction

endpackage

>>> src/ritoa_dabble.sv
// Bit-serial binary to BCD converter using the shift-and-add-three method.
module ritoa_dabble #(
	parameter int VALUE_WIDTH = 32,
	parameter int NDIG = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic [4*NDIG-1:0]      bcd,
	output logic                   done
);
	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] val_q;
	logic [4*NDIG-1:0]      bcd_q;
	logic [4*NDIG-1:0]      adj;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;

	// Every BCD digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			val_q <= val_q << 1;
			bcd_q <= {adj[4*NDIG-2:0], val_q[VALUE_WIDTH-1]};
		end
	end

	assign bcd  = bcd_q;
	assign done = done_q;

endmodule

>>> src/ritoa_emit.sv
// Digit shifter that walks a left-aligned digit vector and drives the output register.
module ritoa_emit #(
	parameter int PW = 36,
	parameter int NDIG = 10,
	parameter int EW = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ritoa_pkg::emit_cmd_t cmd,
	input  logic [EW-1:0]        vec,
	output logic                 digit_valid,
	input  logic                 digit_stall,
	output logic [6:0]           char_code,
	output logic [5:0]           digit_index,
	output logic                 last,
	output logic                 done
);
	import ritoa_pkg::*;

	localparam int SW = $clog2(PW + 1);

	logic [EW-1:0] vec_q;
	logic [EW-1:0] vec_next;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] slots;
	logic [2:0]    dig_bits_q;
	logic          upper_q;
	logic          busy_q;
	logic          started_q;
	logic [5:0]    cnt_q;
	logic          valid_q;
	logic [6:0]    char_q;
	logic [5:0]    idx_q;
	logic          last_q;
	logic [3:0]    dig;
	logic          final_slot;
	logic          adv;
	logic          emit_now;

	always_comb begin
		case (dig_bits_q)
			DIG_BITS_BIN: begin
				dig      = {3'b000, vec_q[EW-1]};
				vec_next = vec_q << 1;
			end
			DIG_BITS_OCT: begin
				dig      = {1'b0, vec_q[EW-1 -: 3]};
				vec_next = vec_q << 3;
			end
			default: begin
				dig      = vec_q[EW-1 -: 4];
				vec_next = vec_q << 4;
			end
		endcase
	end

	always_comb begin
		if (cmd.decimal) begin
			slots = SW'(NDIG);
		end else begin
			case (cmd.dig_bits)
				DIG_BITS_BIN: slots = SW'(PW);
				DIG_BITS_OCT: slots = SW'(PW / 3);
				default:      slots = SW'(PW / 4);
			endcase
		end
	end

	// Leading zero digits are skipped, but the final slot always emits.
	assign final_slot = (slot_q == SW'(1));
	assign adv        = busy_q && (!valid_q || !digit_stall);
	assign emit_now   = started_q || (dig != 4'd0) || final_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			started_q <= 1'b0;
			cnt_q     <= '0;
			slot_q    <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (adv && emit_now) begin
				valid_q <= 1'b1;
			end else if (valid_q && !digit_stall) begin
				valid_q <= 1'b0;
			end
			if (cmd.load) begin
				busy_q    <= 1'b1;
				started_q <= 1'b0;
				cnt_q     <= '0;
				slot_q    <= slots;
			end else if (adv) begin
				slot_q <= slot_q - SW'(1);
				if (emit_now) begin
					started_q <= 1'b1;
					cnt_q     <= cnt_q + 6'd1;
				end
				if (final_slot) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vec_q      <= vec;
			dig_bits_q <= cmd.dig_bits;
			upper_q    <= cmd.upper;
		end else if (adv) begin
			vec_q <= vec_next;
		end
		if (adv && emit_now) begin
			char_q <= digit_char(dig, upper_q);
			idx_q  <= cnt_q + 6'd1;
			last_q <= final_slot;
		end
	end

	assign digit_valid = valid_q;
	assign char_code   = char_q;
	assign digit_index = idx_q;
	assign last        = last_q;
	assign done        = adv && final_slot;

endmodule

>>> src/radix_integer_to_ascii.sv
// Top level of the radix integer-to-ASCII converter: input control and unit wiring.
//
// An item transaction (item_valid, item_stall, value, func) brings one unsigned value and a
// radix mode: binary, octal, decimal, hex lower case or hex upper case. The block answers
// with one digit transaction (digit_valid, digit_stall) per ASCII character, most
// significant first, no leading zeros, carrying char_code, digit_index and last.
// Decimal zero gives a single '0'; zero in the other radices, and an unused mode, give no
// digit transactions at all. One item is worked at a time; item_stall is high while busy.
// Decimal passes through the bit-serial BCD converter, which shifts in all VALUE_WIDTH
// bits, and then through NDIG (10 for 32 bits) digit slots; binary, octal and hex load
// the shifter straight from the input, with one digit slot per digit of the value
// padded to a multiple of 12 bits (36, 12 and 9 at 32 bits). The digit shifter moves
// one digit slot per cycle while the digit side does not stall, and sets the pace. A
// stall on the digit side holds the output register and freezes the shifter; the last
// digit may wait in the output register while the next item is already taken. Reset
// clears all control state and drops digit_valid; nothing else is kept between items.
`include "radix_integer_to_ascii_macros.svh"
module radix_integer_to_ascii #(
	parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [2:0]             func,
	output logic                   digit_valid,
	input  logic                   digit_stall,
	output logic [6:0]             char_code,
	output logic [5:0]             digit_index,
	output logic                   last
);
	import ritoa_pkg::*;

	// Decimal digit count is floor(width * log10(2)) + 1.
	localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	// Padding to a multiple of 12 bits lets 1, 3 and 4 bit digits all align.
	localparam int PW = ((VALUE_WIDTH + 11) / 12) * 12;
	localparam int EW = (PW > 4 * NDIG) ? PW : 4 * NDIG;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_EMIT
	} state_t;

	state_t            st_q;
	logic              accept;
	logic              func_ok;
	logic              value_zero;
	logic              dab_start;
	logic              dab_done;
	logic [4*NDIG-1:0] bcd;
	logic              emit_done;
	emit_cmd_t         cmd;
	logic [EW-1:0]     vec;
	logic [PW-1:0]     padded;

	assign item_stall = (st_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign func_ok    = (func <= FUNC_HEXU);
	assign value_zero = (value == '0);
	assign dab_start  = accept && (func == FUNC_DEC);
	assign padded     = PW'(value);

	// The shifter is loaded straight from the input for the power-of-two radices, and
	// from the BCD converter once it finishes for decimal. Zero in a power-of-two radix
	// and an unused mode load nothing, so the item simply vanishes.
	always_comb begin
		cmd.load    = dab_done || (accept && func_ok && (func != FUNC_DEC) && !value_zero);
		cmd.decimal = dab_done;
		cmd.upper   = !dab_done && (func == FUNC_HEXU);
		if (dab_done) begin
			cmd.dig_bits = DIG_BITS_HEX;
		end else begin
			case (func)
				FUNC_BIN: cmd.dig_bits = DIG_BITS_BIN;
				FUNC_OCT: cmd.dig_bits = DIG_BITS_OCT;
				default:  cmd.dig_bits = DIG_BITS_HEX;
			endcase
		end
		if (dab_done) begin
			vec = EW'(bcd) << (EW - 4 * NDIG);
		end else begin
			vec = EW'(padded) << (EW - PW);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (dab_start) begin
						st_q <= ST_DABBLE;
					end else if (cmd.load) begin
						st_q <= ST_EMIT;
					end
				end
				ST_DABBLE: begin
					if (dab_done) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_done) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	ritoa_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NDIG(NDIG)
	) u_dabble (
		.clk(clk),
		.arst_n(arst_n),
		.start(dab_start),
		.value(value),
		.bcd(bcd),
		.done(dab_done)
	);

	ritoa_emit #(
		.PW(PW),
		.NDIG(NDIG),
		.EW(EW)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.vec(vec),
		.digit_valid(digit_valid),
		.digit_stall(digit_stall),
		.char_code(char_code),
		.digit_index(digit_index),
		.last(last),
		.done(emit_done)
	);

	// An item with an unused mode leaves the block ready for the next one.
	`RITOA_ASSERT_NXT(a_bad_func_ready, clk, arst_n, accept && (func > FUNC_HEXU), !item_stall)
	// The BCD converter only finishes while the control waits for it.
	`RITOA_ASSERT_IMP(a_dab_done_state, clk, arst_n, dab_done, st_q == ST_DABBLE)
	// A digit that is not the last one means the shifter still has slots to go.
	`RITOA_ASSERT_IMP(a_mid_digit_busy, clk, arst_n, digit_valid && !last, st_q == ST_EMIT)

endmodule

>>> tb/sv/tb_radix_integer_to_ascii.sv
// Self-checking testbench for the radix integer-to-ASCII converter.
module tb_radix_integer_to_ascii;
	import ritoa_pkg::*;

	// Radix modes above upper-case hex carry no meaning; the block must drop them silently.
	localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;

	// Character bases used by the digit predictor.
	localparam logic [6:0] ASCII_ZERO    = 7'h30;
	localparam logic [6:0] ASCII_LOWER_A = 7'h61;
	localparam logic [6:0] ASCII_UPPER_A = 7'h41;

	// The run is stopped as failed if it ever gets this far.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Quiet time after the last expected digit.
	localparam int unsigned TAIL_CYCLES = 120;

	// One digit transaction as it should appear on the output side.
	typedef struct packed {
		logic [6:0] char_code;
		logic [5:0] digit_index;
		logic       last;
	} digit_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        item_valid  = 1'b0;
	logic        item_stall;
	logic [31:0] value       = '0;
	logic [2:0]  func        = FUNC_BIN;
	logic        digit_valid;
	logic        digit_stall = 1'b0;
	logic [6:0]  char_code;
	logic [5:0]  digit_index;
	logic        last;

	// Digits predicted for accepted values, oldest first.
	digit_t      pending_digits[$];
	int unsigned mismatch_count     = 0;
	int unsigned cycle_count        = 0;
	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int unsigned sender_idle_pct    = 0;
	int unsigned receiver_stall_pct = 0;

	radix_integer_to_ascii dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      (value),
		.func       (func),
		.digit_valid(digit_valid),
		.digit_stall(digit_stall),
		.char_code  (char_code),
		.digit_index(digit_index),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost digit ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Computes the digit string of one value in the selected radix, most significant
	// digit first, and queues one expected transaction per character. Zero yields a
	// single '0' in decimal and nothing in the other radices; unused modes yield nothing.
	function automatic void predict_digits(input logic [31:0] v, input logic [2:0] f);
		int unsigned radix;
		logic [6:0]  letter_base;
		logic [31:0] rest;
		logic [3:0]  digs[32];
		int          n;
		digit_t      d;
		letter_base = ASCII_LOWER_A;
		case (f)
			FUNC_BIN: radix = 2;
			FUNC_OCT: radix = 8;
			FUNC_DEC: radix = 10;
			FUNC_HEXL: radix = 16;
			FUNC_HEXU: begin
				radix = 16;
				letter_base = ASCII_UPPER_A;
			end
			default: radix = 0;
		endcase
		if (radix == 0)
			return;
		rest = v;
		n = 0;
		if (rest == '0) begin
			if (f != FUNC_DEC)
				return;
			digs[0] = 4'd0;
			n = 1;
		end else begin
			while (rest != '0) begin
				digs[n] = 4'(rest % radix);
				rest = rest / radix;
				n++;
			end
		end
		// Digits were collected least significant first, so walk them backwards.
		for (int k = 0; k < n; k++) begin
			if (digs[n-1-k] < 4'd10)
				d.char_code = ASCII_ZERO + 7'(digs[n-1-k]);
			else
				d.char_code = letter_base + 7'(digs[n-1-k]) - 7'd10;
			d.digit_index = 6'(k + 1);
			d.last = (k == n - 1);
			pending_digits.push_back(d);
		end
	endfunction

	// Draws a value whose length in bits is spread evenly, so that short and long digit
	// strings are equally common, with an occasional zero.
	function automatic logic [31:0] random_value();
		int unsigned nbits;
		logic [31:0] v;
		if ($urandom_range(99) < 5)
			return '0;
		nbits = $urandom_range(32, 1);
		v = $urandom;
		if (nbits < 32)
			v &= (32'd1 << nbits) - 32'd1;
		v[nbits-1] = 1'b1;
		return v;
	endfunction

	// Offers one item, holding it steady while the block stalls, and records the
	// expected digits at the edge where the transaction completes. It is always entered
	// and left right after a rising edge; item_valid stays high on the way out so that
	// back-to-back items keep valid asserted without a drop.
	task automatic send_item(input logic [31:0] v, input logic [2:0] f);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		value <= v;
		func <= f;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_digits(v, f);
	endtask

	// Holds the sender back until every predicted digit has been received.
	task automatic wait_for_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_digits.size() != 0)
			@(posedge clk);
	endtask

	// Largest and smallest nonzero values in every radix, plus letter digits in both
	// cases and the first ten-digit decimal value.
	task automatic test_extremes();
		for (int m = FUNC_BIN; m <= FUNC_HEXU; m++) begin
			send_item(32'h0000_0001, 3'(m));
			send_item(32'hFFFF_FFFF, 3'(m));
		end
		send_item(32'h8000_0000, FUNC_BIN);
		send_item(32'hFEDC_BA98, FUNC_HEXL);
		send_item(32'hFEDC_BA98, FUNC_HEXU);
		send_item(32'd1000000000, FUNC_DEC);
	endtask

	// Zero gives one '0' in decimal and no transactions at all in the other radices.
	task automatic test_zero_values();
		for (int m = FUNC_BIN; m <= FUNC_HEXU; m++)
			send_item('0, 3'(m));
	endtask

	// Unused radix modes must be accepted and produce nothing, even for a full value.
	task automatic test_unused_modes();
		for (int m = FUNC_FIRST_UNUSED; m <= FUNC_LAST_UNUSED; m++)
			send_item(32'hFFFF_FFFF, 3'(m));
		send_item('0, FUNC_LAST_UNUSED);
	endtask

	// Random values in every radix with a sprinkle of unused modes. Unused modes do not
	// count toward the item total. Halfway through, the sender waits for the output to
	// drain completely before it goes on.
	task automatic test_random_items(input int unsigned n_items, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned counted;
		logic        paused;
		logic [31:0] v;
		logic [2:0]  f;
		counted = 0;
		paused = 1'b0;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		while (counted < n_items) begin
			v = random_value();
			if ($urandom_range(99) < 6) begin
				f = 3'($urandom_range(FUNC_LAST_UNUSED, FUNC_FIRST_UNUSED));
			end else begin
				f = 3'($urandom_range(FUNC_HEXU, FUNC_BIN));
				counted++;
			end
			send_item(v, f);
			if (!paused && counted >= n_items / 2) begin
				paused = 1'b1;
				wait_for_drain();
			end
		end
	endtask

	// Receiver: checks each completed digit transaction against the oldest prediction
	// and draws a fresh stall decision every cycle. Values are sampled at the rising
	// edge before any register in the block updates.
	initial begin
		digit_t exp_d;
		forever begin
			@(posedge clk);
			if (arst_n && digit_valid && !digit_stall) begin
				if (pending_digits.size() == 0) begin
					$error("unexpected digit: char_code %0d digit_index %0d last %0d",
						char_code, digit_index, last);
					mismatch_count++;
				end else begin
					exp_d = pending_digits.pop_front();
					if (char_code !== exp_d.char_code) begin
						$error("char_code: expected %0d, got %0d", exp_d.char_code, char_code);
						mismatch_count++;
					end
					if (digit_index !== exp_d.digit_index) begin
						$error("digit_index: expected %0d, got %0d", exp_d.digit_index,
							digit_index);
						mismatch_count++;
					end
					if (last !== exp_d.last) begin
						$error("last: expected %0d, got %0d", exp_d.last, last);
						mismatch_count++;
					end
				end
			end
			digit_stall <= arst_n && ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Main sequence: reset once, the directed cases, three random phases (idling pattern
	// turned around in the second, none in the third), a quiet tail to catch stray digits.
	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 11;
		receiver_stall_pct = 87;
		test_extremes();
		test_zero_values();
		test_unused_modes();
		wait_for_drain();

		test_random_items(75, 11, 87);
		wait_for_drain();
		test_random_items(75, 87, 11);
		wait_for_drain();
		test_random_items(70, 0, 0);

		wait_for_drain();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && pending_digits.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/ritoa_pkg.sv
src/ritoa_dabble.sv
src/ritoa_emit.sv
src/radix_integer_to_ascii.sv
tb/sv/tb_radix_integer_to_ascii.sv
